FILE: hdl/rnhp_pkg.sv
// Package for the nearest ray hit picker: item, result and table word types,
// sequencer states, opcode and register codes, and the 32-bit saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package rnhp_pkg;

	localparam int SAT_IN_W = 72;
	localparam int CFG_IDX_W = 3;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EYE_X        = 3'd0,
		CFG_EYE_Y        = 3'd1,
		CFG_EYE_Z        = 3'd2,
		CFG_EYE_W        = 3'd3,
		CFG_OBJECT_COUNT = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LEN_DOT,
		S_LEN_SQRT,
		S_DIR_DIV,
		S_OBJ_LOAD,
		S_SPH_P,
		S_SPH_B_DOT,
		S_SPH_DELTA,
		S_SPH_SQRT,
		S_PL_NN,
		S_PL_SQRT,
		S_PL_NH_DIV,
		S_PL_P_MUL,
		S_PL_NUM,
		S_PL_DEN,
		S_PL_DIV,
		S_PICK,
		S_NEXT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         object_slot;
		logic signed [31:0] object_x;
		logic signed [31:0] object_y;
		logic signed [31:0] object_z;
		logic signed [31:0] object_w;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} item_t;

	typedef struct packed {
		logic        hit_found;
		logic [3:0]  hit_object;
		logic [30:0] hit_distance;
	} result_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
	} obj_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] x);
		logic signed [31:0] r;
		if (x[SAT_IN_W-1:31] == '0 || x[SAT_IN_W-1:31] == '1)
			r = x[31:0];
		else if (x[SAT_IN_W-1])
			r = {1'b1, 31'b0};
		else
			r = {1'b0, {31{1'b1}}};
		return r;
	endfunction

endpackage

FILE: hdl/ray_nearest_hit_picker.sv
// Nearest ray hit over a table of spheres and planes, one shared multiply-accumulate,
// square-root and divide datapath under a sequencer. Depends on rnhp_pkg.
`timescale 1ns / 1ps
//
//  channel  | handshake                | word
//  ---------+--------------------------+-------------------------------------
//  item     | item_valid / item_stall  | item_t: load entry or pick query
//  result   | result_valid/result_stall| result_t: found, object, distance
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data (eye, count)
//
//  A load word is written on acceptance. A query first forms the ray, then takes
//  each sphere and each plane in turn, paced by the bit-serial divider (one quotient
//  bit a cycle) and the 32-step square root. item_stall is high from query acceptance
//  until the result sits in the output register; that register frees the input while
//  the result waits. Reset clears eye registers, object count and control; table
//  entries read as anything until written.

module ray_nearest_hit_picker import rnhp_pkg::*; #(
	parameter int MAX_OBJECTS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int IW       = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int CW       = $clog2(MAX_OBJECTS + 1);
	localparam int VW       = FRAC_BITS + 2;
	localparam int NW       = FRAC_BITS + 34;
	localparam int DW       = NW + 1;
	localparam int DNW      = FRAC_BITS + 3;
	localparam int NMW      = 34;
	localparam int SW       = $clog2(NW + 2);
	localparam int AW       = 68;
	localparam int PW       = 66;
	localparam int SQ_LAST  = 33;
	localparam int DIV_LAST = NW + 1;

	state_t state_q, state_d;
	logic [SW-1:0] step_q;
	logic [1:0]    comp_q;
	logic          wrap;

	logic signed [31:0] eye_x_q, eye_y_q, eye_z_q, eye_w_q;
	logic [4:0]         count_q;

	obj_t tbl_q [MAX_OBJECTS];

	logic signed [31:0]   d_q [3];
	logic signed [31:0]   o_q [3];
	logic signed [31:0]   p_q [3];
	logic signed [VW-1:0] v_q [3];
	logic signed [VW-1:0] nh_q [3];
	logic signed [31:0]   c_q [3];
	logic signed [31:0]   w_q;
	logic signed [31:0]   b_q;
	logic signed [NMW-1:0] num_q;
	logic signed [DNW-1:0] den_q;
	logic signed [DW-1:0]  t_q;

	logic [CW-1:0] i_q, n_q;
	logic [30:0]   best_q;
	logic [CW-1:0] idx_q;
	logic          found_q;

	logic signed [32:0]   mac_a, mac_b;
	logic                 mac_neg;
	logic signed [PW-1:0] prod_q;
	logic                 sign_q;
	logic signed [AW-1:0] acc_q;
	logic [SW-1:0]        mac_end;
	logic                 mac_state, mac_last;

	logic [63:0] x_q, r_q, bit_q;
	logic [63:0] r_plus;
	logic        sq_last, r_zero;

	logic [NW-1:0]        dmag_q;
	logic [31:0]          rem_q, dd_q;
	logic                 dneg_q;
	logic [32:0]          rem_sh;
	logic                 rem_ge;
	logic signed [DW-1:0] div_num, q_s;
	logic signed [32:0]   div_den;
	logic [NW-1:0]        num_mag;
	logic [31:0]          den_mag;
	logic                 div_state, div_last;

	logic signed [DNW-1:0] den_w;
	logic                  item_acc, out_free, i_done;
	logic signed [32:0]    s_s;
	logic signed [31:0]    eye_dz, pz_d;
	logic [SW-1:0]         stm2;
	logic [1:0]            j, j2;
	obj_t                  tbl_rd;
	result_t               result_q;
	logic                  result_valid_q;

	assign item_acc  = item_valid && !item_stall;
	assign out_free  = !result_valid_q || !result_stall;
	assign i_done    = (i_q == n_q);
	assign tbl_rd    = tbl_q[i_q[IW-1:0]];
	assign sq_last   = (step_q == SW'(SQ_LAST));
	assign div_last  = (step_q == SW'(DIV_LAST));
	assign r_zero    = (r_q == '0);
	assign den_w     = DNW'(acc_q >>> FRAC_BITS);
	assign s_s       = $signed({1'b0, r_q[31:0]});
	assign r_plus    = r_q + bit_q;
	assign rem_sh    = {rem_q, dmag_q[NW-1]};
	assign rem_ge    = (rem_sh >= {1'b0, dd_q});
	assign q_s       = dneg_q ? -$signed({1'b0, dmag_q}) : $signed({1'b0, dmag_q});
	assign eye_dz    = sat32(SAT_IN_W'(eye_z_q) - SAT_IN_W'(eye_w_q));
	assign pz_d      = sat32(SAT_IN_W'(item.point_z) - SAT_IN_W'(eye_dz));
	assign stm2      = step_q - SW'(2);
	assign j         = (step_q[1:0] == 2'd3) ? 2'd0 : step_q[1:0];
	assign j2        = (stm2[1:0] == 2'd3) ? 2'd0 : stm2[1:0];
	assign mac_end   = (state_q == S_SPH_DELTA) ? SW'(6) : SW'(4);
	assign mac_last  = (step_q == mac_end);
	assign mac_state = (state_q == S_LEN_DOT) || (state_q == S_SPH_B_DOT) ||
		(state_q == S_SPH_DELTA) || (state_q == S_PL_NN) ||
		(state_q == S_PL_NUM) || (state_q == S_PL_DEN);
	assign div_state = (state_q == S_DIR_DIV) || (state_q == S_PL_NH_DIV) ||
		(state_q == S_PL_DIV);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (item_acc && item.opcode == OP_QUERY) state_d = S_LEN_DOT;
			S_LEN_DOT:   if (mac_last) state_d = S_LEN_SQRT;
			S_LEN_SQRT:  if (sq_last) state_d = r_zero ? S_OBJ_LOAD : S_DIR_DIV;
			S_DIR_DIV:   if (div_last && comp_q == 2'd2) state_d = S_OBJ_LOAD;
			S_OBJ_LOAD: begin
				if (i_done)
					state_d = S_OUT;
				else if (tbl_rd.w > 0)
					state_d = S_SPH_P;
				else
					state_d = S_PL_NN;
			end
			S_SPH_P:     state_d = S_SPH_B_DOT;
			S_SPH_B_DOT: if (mac_last) state_d = S_SPH_DELTA;
			S_SPH_DELTA: if (mac_last) state_d = acc_q[AW-1] ? S_NEXT : S_SPH_SQRT;
			S_SPH_SQRT:  if (sq_last) state_d = S_PICK;
			S_PL_NN:     if (mac_last) state_d = S_PL_SQRT;
			S_PL_SQRT:   if (sq_last) state_d = r_zero ? S_NEXT : S_PL_NH_DIV;
			S_PL_NH_DIV: if (div_last && comp_q == 2'd2) state_d = S_PL_P_MUL;
			S_PL_P_MUL:  if (step_q == SW'(1) && comp_q == 2'd2) state_d = S_PL_NUM;
			S_PL_NUM:    if (mac_last) state_d = S_PL_DEN;
			S_PL_DEN:    if (mac_last) state_d = (den_w == '0) ? S_NEXT : S_PL_DIV;
			S_PL_DIV:    if (div_last) state_d = S_PICK;
			S_PICK:      state_d = S_NEXT;
			S_NEXT:      state_d = S_OBJ_LOAD;
			S_OUT:       if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// outputs and shared operand selection
	always_comb begin
		item_stall = (state_q != S_IDLE);
		cfg_ready  = 1'b1;
		mac_a      = '0;
		mac_b      = '0;
		mac_neg    = 1'b0;
		div_num    = '0;
		div_den    = '0;
		wrap       = 1'b0;
		case (state_q)
			S_LEN_DOT: begin
				mac_a = 33'(d_q[j]);
				mac_b = 33'(d_q[j]);
			end
			S_SPH_B_DOT: begin
				mac_a = 33'(v_q[j]);
				mac_b = 33'(p_q[j]);
			end
			S_SPH_DELTA: begin
				if (step_q == SW'(0)) begin
					mac_a = 33'(b_q);
					mac_b = 33'(b_q);
				end else if (step_q == SW'(1)) begin
					mac_a = 33'(w_q);
					mac_b = 33'(w_q);
				end else begin
					mac_a   = 33'(p_q[j2]);
					mac_b   = 33'(p_q[j2]);
					mac_neg = 1'b1;
				end
			end
			S_PL_NN: begin
				mac_a = 33'(c_q[j]);
				mac_b = 33'(c_q[j]);
			end
			S_PL_P_MUL: begin
				mac_a = -33'(w_q);
				mac_b = 33'(nh_q[comp_q]);
				wrap  = (step_q == SW'(1)) && (comp_q != 2'd2);
			end
			S_PL_NUM: begin
				mac_a = 33'(nh_q[j]);
				mac_b = 33'(p_q[j]);
			end
			S_PL_DEN: begin
				mac_a = 33'(nh_q[j]);
				mac_b = 33'(v_q[j]);
			end
			S_DIR_DIV: begin
				div_num = DW'(d_q[comp_q]) <<< FRAC_BITS;
				div_den = $signed({1'b0, r_q[31:0]});
				wrap    = div_last && (comp_q != 2'd2);
			end
			S_PL_NH_DIV: begin
				div_num = DW'(c_q[comp_q]) <<< FRAC_BITS;
				div_den = $signed({1'b0, r_q[31:0]});
				wrap    = div_last && (comp_q != 2'd2);
			end
			S_PL_DIV: begin
				div_num = DW'(num_q) <<< FRAC_BITS;
				div_den = 33'(den_q);
			end
			default: ;
		endcase
		num_mag = div_num[DW-1] ? NW'(-div_num) : NW'(div_num);
		den_mag = div_den[32] ? 32'(-div_den) : 32'(div_den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			step_q         <= '0;
			comp_q         <= '0;
			result_valid_q <= 1'b0;
			eye_x_q        <= '0;
			eye_y_q        <= '0;
			eye_z_q        <= '0;
			eye_w_q        <= '0;
			count_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q || wrap || state_q == S_IDLE)
				step_q <= '0;
			else
				step_q <= step_q + SW'(1);
			if (state_d != state_q)
				comp_q <= '0;
			else if (wrap)
				comp_q <= comp_q + 2'd1;
			if (state_q == S_OUT && out_free)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_EYE_X:        eye_x_q <= cfg_data;
					CFG_EYE_Y:        eye_y_q <= cfg_data;
					CFG_EYE_Z:        eye_z_q <= cfg_data;
					CFG_EYE_W:        eye_w_q <= cfg_data;
					CFG_OBJECT_COUNT: count_q <= cfg_data[4:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mac_a * mac_b;
		sign_q <= mac_neg;

		if (item_acc && item.opcode == OP_LOAD && int'(item.object_slot) < MAX_OBJECTS)
			tbl_q[IW'(item.object_slot)] <= '{item.object_x, item.object_y,
				item.object_z, item.object_w};

		if (item_acc && item.opcode == OP_QUERY) begin
			d_q[0]  <= item.point_x;
			d_q[1]  <= item.point_y;
			d_q[2]  <= pz_d;
			o_q[0]  <= sat32(SAT_IN_W'(item.point_x) + SAT_IN_W'(eye_x_q));
			o_q[1]  <= sat32(SAT_IN_W'(item.point_y) + SAT_IN_W'(eye_y_q));
			o_q[2]  <= sat32(SAT_IN_W'(item.point_z) + SAT_IN_W'(eye_w_q));
			i_q     <= '0;
			n_q     <= (int'(count_q) > MAX_OBJECTS) ? CW'(MAX_OBJECTS) : CW'(count_q);
			best_q  <= '1;
			idx_q   <= '0;
			found_q <= 1'b0;
		end

		if (mac_state) begin
			if (step_q == SW'(0))
				acc_q <= '0;
			else if (!mac_last && step_q != mac_end - SW'(0) && step_q < mac_end)
				acc_q <= sign_q ? acc_q - AW'(prod_q) : acc_q + AW'(prod_q);
		end

		// square root: load, 32 iterations, result in r_q
		if (state_q == S_LEN_SQRT || state_q == S_SPH_SQRT || state_q == S_PL_SQRT) begin
			if (step_q == SW'(0)) begin
				x_q   <= acc_q[63:0];
				r_q   <= '0;
				bit_q <= 64'(1) << 62;
			end else if (!sq_last) begin
				if (x_q >= r_plus) begin
					x_q <= x_q - r_plus;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end

		// divider: load magnitudes, one quotient bit a cycle, then sign
		if (div_state) begin
			if (step_q == SW'(0)) begin
				dmag_q <= num_mag;
				rem_q  <= '0;
				dd_q   <= den_mag;
				dneg_q <= div_num[DW-1] ^ div_den[32];
			end else if (!div_last) begin
				rem_q  <= rem_ge ? 32'(rem_sh - {1'b0, dd_q}) : rem_sh[31:0];
				dmag_q <= {dmag_q[NW-2:0], rem_ge};
			end
		end

		case (state_q)
			S_LEN_SQRT: if (sq_last && r_zero) begin
				v_q[0] <= '0;
				v_q[1] <= '0;
				v_q[2] <= '0;
			end
			S_DIR_DIV:   if (div_last) v_q[comp_q] <= VW'(q_s);
			S_OBJ_LOAD: begin
				c_q[0] <= tbl_rd.x;
				c_q[1] <= tbl_rd.y;
				c_q[2] <= tbl_rd.z;
				w_q    <= tbl_rd.w;
			end
			S_SPH_P: begin
				p_q[0] <= sat32(SAT_IN_W'(c_q[0]) - SAT_IN_W'(o_q[0]));
				p_q[1] <= sat32(SAT_IN_W'(c_q[1]) - SAT_IN_W'(o_q[1]));
				p_q[2] <= sat32(SAT_IN_W'(c_q[2]) - SAT_IN_W'(o_q[2]));
			end
			S_SPH_B_DOT: if (mac_last) b_q <= sat32(SAT_IN_W'(acc_q >>> FRAC_BITS));
			S_SPH_SQRT:  if (sq_last) t_q <= (b_q >= 0) ? DW'(b_q) - DW'(s_s) : DW'(b_q) + DW'(s_s);
			S_PL_NH_DIV: if (div_last) nh_q[comp_q] <= VW'(q_s);
			S_PL_P_MUL:  if (step_q == SW'(1))
				p_q[comp_q] <= sat32(SAT_IN_W'(prod_q >>> FRAC_BITS) - SAT_IN_W'(o_q[comp_q]));
			S_PL_NUM:    if (mac_last) num_q <= NMW'(acc_q >>> FRAC_BITS);
			S_PL_DEN:    if (mac_last) den_q <= den_w;
			S_PL_DIV:    if (div_last) t_q <= q_s;
			S_PICK: begin
				if (t_q > 0 && t_q < DW'($signed({1'b0, best_q}))) begin
					best_q  <= t_q[30:0];
					idx_q   <= i_q;
					found_q <= 1'b1;
				end
			end
			S_NEXT:      i_q <= i_q + CW'(1);
			S_OUT: if (out_free) begin
				result_q.hit_found    <= found_q;
				result_q.hit_object   <= found_q ? 4'(idx_q) : 4'd0;
				result_q.hit_distance <= best_q;
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the output state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OBJ_LOAD || state_q == S_PICK || state_q == S_NEXT) |-> i_q <= n_q)
		else $error("object counter ran past the count");

	a_no_hit_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !found_q) |-> best_q == '1)
		else $error("distance moved without a hit");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(div_state && step_q != SW'(0)) |-> dd_q != '0)
		else $error("divider started with a zero divisor");

endmodule

FILE: tb/sv/ray_nearest_hit_picker_tb.sv
// Testbench for ray_nearest_hit_picker: directed and random load and pick words,
// checked against a fixed-point nearest-hit predictor. Depends on rnhp_pkg and the DUT.
`timescale 1ns / 1ps

module ray_nearest_hit_picker_tb import rnhp_pkg::*; ;

	typedef longint vec3_t [3];

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	// predictor state
	longint      eye [4];
	int unsigned obj_count;
	longint      tab_x [16], tab_y [16], tab_z [16], tab_w [16];

	result_t     pending_hits [$];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_len = 0;
	int          n_loads = 0, n_queries = 0, n_hits = 0, n_results = 0;

	ray_nearest_hit_picker dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#400ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r, b;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] sq_len(vec3_t a);
		return a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
	endfunction

	// scale to unit length at 16 fraction bits; a zero vector stays zero
	function automatic bit unit_vec(vec3_t a, output vec3_t u);
		longint len;
		len = longint'(root64(sq_len(a)));
		for (int i = 0; i < 3; i++)
			u[i] = (len != 0) ? (a[i] * 65536) / len : 0;
		return len != 0;
	endfunction

	function automatic result_t pick_nearest(item_t q);
		vec3_t d, v, o, c, nh, p;
		longint best, t, b, s, w, num, den;
		logic [63:0] lhs, pp;
		int unsigned n, idx;
		bit found;
		result_t r;
		best = 64'sd2147483647;
		idx = 0;
		found = 0;
		d[0] = longint'(q.point_x);
		d[1] = longint'(q.point_y);
		d[2] = clamp32(longint'(q.point_z) - clamp32(eye[2] - eye[3]));
		void'(unit_vec(d, v));
		o[0] = clamp32(longint'(q.point_x) + eye[0]);
		o[1] = clamp32(longint'(q.point_y) + eye[1]);
		o[2] = clamp32(longint'(q.point_z) + eye[3]);
		n = (obj_count > 16) ? 16 : obj_count;
		for (int i = 0; i < n; i++) begin
			w = tab_w[i];
			c[0] = tab_x[i];
			c[1] = tab_y[i];
			c[2] = tab_z[i];
			if (w > 0) begin
				for (int k = 0; k < 3; k++) p[k] = clamp32(c[k] - o[k]);
				b = clamp32((v[0] * p[0] + v[1] * p[1] + v[2] * p[2]) >>> 16);
				lhs = b * b + w * w;
				pp = sq_len(p);
				if (lhs < pp) continue;
				s = longint'(root64(lhs - pp));
				t = (b >= 0) ? b - s : b + s;
			end else begin
				if (!unit_vec(c, nh)) continue;
				for (int k = 0; k < 3; k++) p[k] = clamp32(((-w * nh[k]) >>> 16) - o[k]);
				num = (nh[0] * p[0] + nh[1] * p[1] + nh[2] * p[2]) >>> 16;
				den = (nh[0] * v[0] + nh[1] * v[1] + nh[2] * v[2]) >>> 16;
				if (den == 0) continue;
				t = (num * 65536) / den;
			end
			if (t > 0 && t < best) begin
				best = t;
				idx = i;
				found = 1;
			end
		end
		r.hit_found = found;
		r.hit_object = found ? idx[3:0] : 4'd0;
		r.hit_distance = best[30:0];
		return r;
	endfunction

	// receiver: random stall, or a long hold when one is asked for
	always @(posedge clk) begin
		if (hold_len > 0) begin
			result_stall <= 1'b1;
			hold_len = hold_len - 1;
		end else
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %p", result);
			end else begin
				exp_r = pending_hits.pop_front();
				if (exp_r.hit_found !== result.hit_found
					|| exp_r.hit_object !== result.hit_object
					|| exp_r.hit_distance !== result.hit_distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t mismatch: expected found %0d obj %0d dist %0d, got %0d %0d %0d",
							$realtime, exp_r.hit_found, exp_r.hit_object,
							exp_r.hit_distance, result.hit_found, result.hit_object,
							result.hit_distance);
				end
			end
		end
	end

	task automatic send_word(item_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (w.opcode == OP_QUERY) begin
			pending_hits.push_back(pick_nearest(w));
			n_queries++;
			if (pending_hits[$].hit_found) n_hits++;
		end else begin
			tab_x[w.object_slot] = longint'(w.object_x);
			tab_y[w.object_slot] = longint'(w.object_y);
			tab_z[w.object_slot] = longint'(w.object_z);
			tab_w[w.object_slot] = longint'(w.object_w);
			n_loads++;
		end
	endtask

	// wait until every result is in, then let a trailing load settle
	task automatic drain();
		item_valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_OBJECT_COUNT) obj_count = 32'(val[4:0]);
		else eye[idx] = longint'(signed'(val));
	endtask

	function automatic int rq(int unsigned m);
		return int'($urandom_range(0, 2 * m)) - int'(m);
	endfunction

	function automatic item_t load_word(logic [3:0] slot, int x, int y, int z, int w);
		item_t it;
		it = '0;
		it.opcode = OP_LOAD;
		it.object_slot = slot;
		it.object_x = x;
		it.object_y = y;
		it.object_z = z;
		it.object_w = w;
		return it;
	endfunction

	function automatic item_t query_word(int x, int y, int z);
		item_t it;
		it = '0;
		it.opcode = OP_QUERY;
		it.point_x = x;
		it.point_y = y;
		it.point_z = z;
		return it;
	endfunction

	// queries, or objects in front of the eye (mostly spheres, some planes)
	function automatic item_t scene_word(bit wild);
		item_t it;
		if (wild) begin
			it = '0;
			{it.opcode, it.object_slot} = 5'($urandom);
			it.object_x = $urandom;
			it.object_y = $urandom;
			it.object_z = $urandom;
			it.object_w = $urandom;
			it.point_x = $urandom;
			it.point_y = $urandom;
			it.point_z = $urandom;
			return it;
		end
		if ($urandom_range(0, 99) < 45) begin
			if ($urandom_range(0, 3) != 0)
				return load_word(4'($urandom_range(0, 15)), rq(3 << 16), rq(3 << 16),
					$urandom_range(5 << 16, 30 << 16), $urandom_range(1 << 15, 4 << 16));
			return load_word(4'($urandom_range(0, 15)), rq(1 << 16), rq(1 << 16),
				rq(1 << 16), -int'($urandom_range(0, 40 << 16)));
		end
		return query_word(rq(2 << 16), rq(2 << 16), rq(1 << 16));
	endfunction

	task automatic set_view(bit extreme);
		if (extreme) begin
			write_reg(CFG_EYE_X, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
			write_reg(CFG_EYE_Y, $urandom);
			write_reg(CFG_EYE_Z, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
			write_reg(CFG_EYE_W, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
		end else begin
			write_reg(CFG_EYE_X, rq(2 << 16));
			write_reg(CFG_EYE_Y, rq(2 << 16));
			write_reg(CFG_EYE_Z, -int'($urandom_range(1 << 16, 10 << 16)));
			write_reg(CFG_EYE_W, rq(1 << 16));
		end
		write_reg(CFG_OBJECT_COUNT, $urandom_range(1, 16));
	endtask

	task automatic test_empty_query();
		send_word(query_word(32'sh0001_0000, 0, 0));
		drain();
	endtask

	task automatic test_fill_table();
		item_t it;
		for (int s = 0; s < 16; s++) begin
			it = scene_word(0);
			if (it.opcode != OP_LOAD)
				it = load_word(s[3:0], rq(3 << 16), rq(3 << 16), 10 << 16, 2 << 16);
			send_word(it);
		end
		for (int s = 0; s < 16; s++)
			send_word(load_word(s[3:0], rq(3 << 16), rq(3 << 16),
				$urandom_range(5 << 16, 30 << 16), $urandom_range(1 << 15, 4 << 16)));
		drain();
	endtask

	task automatic test_special_cases();
		set_view(0);
		write_reg(CFG_OBJECT_COUNT, 16);
		// zero normal plane, plane parallel to the ray, and a facing plane
		send_word(load_word(4'd0, 0, 0, 0, -(5 << 16)));
		send_word(load_word(4'd1, 1 << 16, 0, 0, -(3 << 16)));
		send_word(load_word(4'd2, 0, 0, 1 << 16, -(20 << 16)));
		send_word(load_word(4'd15, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF));
		send_word(query_word(0, 0, 0));
		// zero-length direction
		send_word(query_word(0, 0, int'(clamp32(eye[2] - eye[3]))));
		send_word(query_word(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
		send_word(query_word(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
		drain();
		write_reg(CFG_OBJECT_COUNT, 31);
		send_word(query_word(rq(1 << 16), rq(1 << 16), 0));
		drain();
		write_reg(CFG_OBJECT_COUNT, 0);
		send_word(query_word(0, 0, 0));
		drain();
		set_view(1);
		send_word(query_word(rq(1 << 16), 0, 0));
		drain();
	endtask

	task automatic test_random_phase(int n_items, int s_pct, int r_pct, bit extreme);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		set_view(extreme);
		for (int i = 0; i < n_items; i++)
			send_word(scene_word($urandom_range(0, 99) < 15));
		drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_OBJECT_COUNT, 16);
		hold_len = 20000;
		for (int i = 0; i < 8; i++)
			send_word(query_word(rq(2 << 16), rq(2 << 16), rq(1 << 16)));
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_query();
		test_fill_table();
		test_special_cases();
		test_fill_table();
		test_random_phase(150, 29, 56, 0);
		test_random_phase(150, 29, 56, 1);
		test_backpressure();
		test_random_phase(150, 56, 29, 0);
		test_random_phase(150, 56, 29, 0);
		test_random_phase(150, 0, 0, 0);
		test_random_phase(120, 0, 0, 0);
		repeat (50) @(posedge clk);
		$display("covered %0d table loads and %0d pick queries, %0d of them hits, %0d results",
			n_loads, n_queries, n_hits, n_results);
		$display("eye and count settings swept through extremes and three idling mixes");
		if (mismatches == 0 && pending_hits.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
